// File: rtl/core/srtd_pkg.sv
// shared types and constants for the shape record to edge decoder
`timescale 1ns / 1ps
package srtd_pkg;

	localparam int COORD_BITS_DEF = 32;
	localparam int WORD_W         = 32;
	localparam int STYLE_W        = 16;
	localparam int BANK_W         = 8;
	localparam int FLAGS_W        = 6;
	localparam int QUEUE_DEPTH    = 2;
	localparam int PADDR_W        = 4;
	localparam int PDATA_W        = 32;

	// change flag bit positions
	localparam int FLG_MOVE    = 0;
	localparam int FLG_FILLTAB = 1;
	localparam int FLG_LINETAB = 2;
	localparam int FLG_FILL0   = 3;
	localparam int FLG_FILL1   = 4;
	localparam int FLG_LINE    = 5;

	// register indexes
	localparam logic [1:0] REG_ORIGIN_X = 2'd0;
	localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
	localparam logic [1:0] REG_LINE_TAB = 2'd2;

	typedef enum logic [2:0] {
		OP_STYLE,
		OP_LINE_XY,
		OP_LINE_Y,
		OP_LINE_X,
		OP_CURVE
	} op_kind_t;

	typedef struct packed {
		op_kind_t                   kind;
		logic signed [WORD_W-1:0]   dx;
		logic signed [WORD_W-1:0]   dy;
		logic signed [WORD_W-1:0]   cdx;
		logic signed [WORD_W-1:0]   cdy;
		logic [FLAGS_W-1:0]         flags;
		logic [STYLE_W-1:0]         fill0;
		logic [STYLE_W-1:0]         fill1;
		logic [STYLE_W-1:0]         line;
	} op_t;

	typedef struct packed {
		logic                       wr_x;
		logic                       wr_y;
		logic                       wr_lt;
		logic [PDATA_W-1:0]         data;
	} cfg_wr_t;

endpackage

// File: rtl/core/srtd_front.sv
// front end: accepts records and classifies them into queue operations
`timescale 1ns / 1ps
module srtd_front (
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            is_edge,
	input  logic                            is_straight,
	input  logic                            general_line,
	input  logic                            vertical_line,
	input  logic signed [srtd_pkg::WORD_W-1:0]  delta_x,
	input  logic signed [srtd_pkg::WORD_W-1:0]  delta_y,
	input  logic signed [srtd_pkg::WORD_W-1:0]  control_dx,
	input  logic signed [srtd_pkg::WORD_W-1:0]  control_dy,
	input  logic [srtd_pkg::FLAGS_W-1:0]    change_flags,
	input  logic [srtd_pkg::STYLE_W-1:0]    new_fill0,
	input  logic [srtd_pkg::STYLE_W-1:0]    new_fill1,
	input  logic [srtd_pkg::STYLE_W-1:0]    new_line,
	input  logic                            q_full,
	output logic                            q_push,
	output srtd_pkg::op_t                   q_op
);
	import srtd_pkg::*;

	op_kind_t kind;

	always_comb begin
		if (!is_edge) begin
			kind = OP_STYLE;
		end else if (!is_straight) begin
			kind = OP_CURVE;
		end else if (general_line) begin
			kind = OP_LINE_XY;
		end else if (vertical_line) begin
			kind = OP_LINE_Y;
		end else begin
			kind = OP_LINE_X;
		end
	end

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_op.kind  = kind;
		q_op.dx    = delta_x;
		q_op.dy    = delta_y;
		q_op.cdx   = control_dx;
		q_op.cdy   = control_dy;
		q_op.flags = change_flags;
		q_op.fill0 = new_fill0;
		q_op.fill1 = new_fill1;
		q_op.line  = new_line;
	end

endmodule

// File: rtl/core/srtd_queue.sv
// short queue of classified operations between front and back end
`timescale 1ns / 1ps
module srtd_queue #(
	parameter int DEPTH = srtd_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  srtd_pkg::op_t  push_op,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output srtd_pkg::op_t  head_op
);
	import srtd_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	op_t           slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head_op   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/core/srtd_back.sv
// back end: pen and style state, edge generation and output register
`timescale 1ns / 1ps
module srtd_back #(
	parameter int COORD_BITS = srtd_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  srtd_pkg::cfg_wr_t                   cfg_wr,
	input  logic                                q_not_empty,
	input  srtd_pkg::op_t                       q_head,
	output logic                                q_pop,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [srtd_pkg::WORD_W-1:0]  start_x,
	output logic signed [srtd_pkg::WORD_W-1:0]  start_y,
	output logic signed [srtd_pkg::WORD_W-1:0]  ctrl_x,
	output logic signed [srtd_pkg::WORD_W-1:0]  ctrl_y,
	output logic signed [srtd_pkg::WORD_W-1:0]  end_x,
	output logic signed [srtd_pkg::WORD_W-1:0]  end_y,
	output logic                                is_curve,
	output logic [srtd_pkg::STYLE_W-1:0]        fill0_style,
	output logic [srtd_pkg::STYLE_W-1:0]        fill1_style,
	output logic [srtd_pkg::STYLE_W-1:0]        line_style_out,
	output logic [srtd_pkg::BANK_W-1:0]         fill_table_bank,
	output logic [srtd_pkg::BANK_W-1:0]         line_table_bank
);
	import srtd_pkg::*;

	logic signed [COORD_BITS-1:0] pen_x_q;
	logic signed [COORD_BITS-1:0] pen_y_q;
	logic [STYLE_W-1:0]           fill0_q;
	logic [STYLE_W-1:0]           fill1_q;
	logic [STYLE_W-1:0]           line_q;
	logic [BANK_W-1:0]            fill_bank_q;
	logic [BANK_W-1:0]            line_bank_q;
	logic                         line_known_q;

	logic                         out_valid_q;
	logic signed [WORD_W-1:0]     start_x_q;
	logic signed [WORD_W-1:0]     start_y_q;
	logic signed [WORD_W-1:0]     ctrl_x_q;
	logic signed [WORD_W-1:0]     ctrl_y_q;
	logic signed [WORD_W-1:0]     end_x_q;
	logic signed [WORD_W-1:0]     end_y_q;
	logic                         is_curve_q;
	logic [STYLE_W-1:0]           fill0_style_q;
	logic [STYLE_W-1:0]           fill1_style_q;
	logic [STYLE_W-1:0]           line_style_q;
	logic [BANK_W-1:0]            fill_bank_out_q;
	logic [BANK_W-1:0]            line_bank_out_q;

	logic                         slot_free;
	logic                         is_style;
	logic                         take_edge;
	logic                         take_style;
	logic signed [COORD_BITS-1:0] dx_c;
	logic signed [COORD_BITS-1:0] dy_c;
	logic signed [COORD_BITS-1:0] cdx_c;
	logic signed [COORD_BITS-1:0] cdy_c;
	logic signed [COORD_BITS-1:0] cx;
	logic signed [COORD_BITS-1:0] cy;
	logic signed [COORD_BITS-1:0] ex;
	logic signed [COORD_BITS-1:0] ey;
	logic                         curve;

	assign slot_free  = !out_valid_q || out_ready;
	assign is_style   = (q_head.kind == OP_STYLE);
	assign take_style = q_not_empty && is_style;
	assign take_edge  = q_not_empty && !is_style && slot_free;
	assign q_pop      = take_style || take_edge;

	assign dx_c  = q_head.dx[COORD_BITS-1:0];
	assign dy_c  = q_head.dy[COORD_BITS-1:0];
	assign cdx_c = q_head.cdx[COORD_BITS-1:0];
	assign cdy_c = q_head.cdy[COORD_BITS-1:0];

	always_comb begin
		cx    = '0;
		cy    = '0;
		ex    = pen_x_q;
		ey    = pen_y_q;
		curve = 1'b0;
		case (q_head.kind)
			OP_LINE_XY: begin
				ex = pen_x_q + dx_c;
				ey = pen_y_q + dy_c;
			end
			OP_LINE_Y: begin
				ey = pen_y_q + dy_c;
			end
			OP_LINE_X: begin
				ex = pen_x_q + dx_c;
			end
			OP_CURVE: begin
				cx    = pen_x_q + cdx_c;
				cy    = pen_y_q + cdy_c;
				ex    = cx + dx_c;
				ey    = cy + dy_c;
				curve = 1'b1;
			end
			default: begin
				ex = pen_x_q;
				ey = pen_y_q;
			end
		endcase
	end

	// pen and style state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q      <= '0;
			pen_y_q      <= '0;
			fill0_q      <= '0;
			fill1_q      <= '0;
			line_q       <= '0;
			fill_bank_q  <= '0;
			line_bank_q  <= '0;
			line_known_q <= 1'b0;
		end else begin
			if (cfg_wr.wr_x) begin
				pen_x_q <= cfg_wr.data[COORD_BITS-1:0];
			end
			if (cfg_wr.wr_y) begin
				pen_y_q <= cfg_wr.data[COORD_BITS-1:0];
			end
			if (cfg_wr.wr_lt) begin
				line_known_q <= cfg_wr.data[0];
			end
			if (take_edge) begin
				pen_x_q <= ex;
				pen_y_q <= ey;
			end
			if (take_style) begin
				if (q_head.flags[FLG_MOVE]) begin
					pen_x_q <= dx_c;
					pen_y_q <= dy_c;
				end
				if (q_head.flags[FLG_FILLTAB]) begin
					fill_bank_q <= fill_bank_q + 1'b1;
				end
				if (q_head.flags[FLG_LINETAB]) begin
					line_bank_q  <= line_bank_q + 1'b1;
					line_known_q <= 1'b1;
				end
				if (q_head.flags[FLG_FILL0]) begin
					fill0_q <= q_head.fill0;
				end
				if (q_head.flags[FLG_FILL1]) begin
					fill1_q <= q_head.fill1;
				end
				if (q_head.flags[FLG_LINE]) begin
					line_q <= q_head.line;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take_edge) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_edge) begin
			start_x_q       <= WORD_W'(pen_x_q);
			start_y_q       <= WORD_W'(pen_y_q);
			ctrl_x_q        <= WORD_W'(cx);
			ctrl_y_q        <= WORD_W'(cy);
			end_x_q         <= WORD_W'(ex);
			end_y_q         <= WORD_W'(ey);
			is_curve_q      <= curve;
			fill0_style_q   <= fill0_q;
			fill1_style_q   <= fill1_q;
			line_style_q    <= line_known_q ? line_q : '0;
			fill_bank_out_q <= fill_bank_q;
			line_bank_out_q <= line_bank_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign start_x         = start_x_q;
	assign start_y         = start_y_q;
	assign ctrl_x          = ctrl_x_q;
	assign ctrl_y          = ctrl_y_q;
	assign end_x           = end_x_q;
	assign end_y           = end_y_q;
	assign is_curve        = is_curve_q;
	assign fill0_style     = fill0_style_q;
	assign fill1_style     = fill1_style_q;
	assign line_style_out  = line_style_q;
	assign fill_table_bank = fill_bank_out_q;
	assign line_table_bank = line_bank_out_q;

endmodule

// File: rtl/core/shape_record_to_edge_decoder_top.sv
// Shape record to edge decoder: takes one shape record per cycle while the queue
// has room, and keeps a running pen. The front end classifies each record and
// writes it into a two-entry queue; the back end takes one operation per cycle
// from the queue (style change items even while the output is stalled, edges
// only while it is free), updates pen and style state and, for an edge record,
// loads the output register. Sustained rate is one item per clock unless the
// output stalls; an edge result passes a queue slot, then the output register.
// Registers: origin_x at 0x0, origin_y at 0x4, line_table_initial at 0x8.
`timescale 1ns / 1ps
module shape_record_to_edge_decoder_top #(
	parameter int COORD_BITS = srtd_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [srtd_pkg::PADDR_W-1:0]        paddr,
	input  logic [srtd_pkg::PDATA_W-1:0]        pwdata,
	output logic [srtd_pkg::PDATA_W-1:0]        prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                is_edge,
	input  logic                                is_straight,
	input  logic                                general_line,
	input  logic                                vertical_line,
	input  logic signed [srtd_pkg::WORD_W-1:0]  delta_x,
	input  logic signed [srtd_pkg::WORD_W-1:0]  delta_y,
	input  logic signed [srtd_pkg::WORD_W-1:0]  control_dx,
	input  logic signed [srtd_pkg::WORD_W-1:0]  control_dy,
	input  logic [srtd_pkg::FLAGS_W-1:0]        change_flags,
	input  logic [srtd_pkg::STYLE_W-1:0]        new_fill0,
	input  logic [srtd_pkg::STYLE_W-1:0]        new_fill1,
	input  logic [srtd_pkg::STYLE_W-1:0]        new_line,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [srtd_pkg::WORD_W-1:0]  start_x,
	output logic signed [srtd_pkg::WORD_W-1:0]  start_y,
	output logic signed [srtd_pkg::WORD_W-1:0]  ctrl_x,
	output logic signed [srtd_pkg::WORD_W-1:0]  ctrl_y,
	output logic signed [srtd_pkg::WORD_W-1:0]  end_x,
	output logic signed [srtd_pkg::WORD_W-1:0]  end_y,
	output logic                                is_curve,
	output logic [srtd_pkg::STYLE_W-1:0]        fill0_style,
	output logic [srtd_pkg::STYLE_W-1:0]        fill1_style,
	output logic [srtd_pkg::STYLE_W-1:0]        line_style_out,
	output logic [srtd_pkg::BANK_W-1:0]         fill_table_bank,
	output logic [srtd_pkg::BANK_W-1:0]         line_table_bank
);
	import srtd_pkg::*;

	logic [PDATA_W-1:0] origin_x_q;
	logic [PDATA_W-1:0] origin_y_q;
	logic               line_tab_q;
	logic               wr_en;
	logic [1:0]         reg_idx;
	cfg_wr_t            cfg_wr;

	logic               q_full;
	logic               q_push;
	op_t                q_op;
	logic               q_pop;
	logic               q_not_empty;
	op_t                q_head;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];

	always_comb begin
		cfg_wr.wr_x  = wr_en && (reg_idx == REG_ORIGIN_X);
		cfg_wr.wr_y  = wr_en && (reg_idx == REG_ORIGIN_Y);
		cfg_wr.wr_lt = wr_en && (reg_idx == REG_LINE_TAB);
		cfg_wr.data  = pwdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			line_tab_q <= 1'b0;
		end else begin
			if (cfg_wr.wr_x) begin
				origin_x_q <= pwdata;
			end
			if (cfg_wr.wr_y) begin
				origin_y_q <= pwdata;
			end
			if (cfg_wr.wr_lt) begin
				line_tab_q <= pwdata[0];
			end
		end
	end

	always_comb begin
		case (reg_idx)
			REG_ORIGIN_X: prdata = origin_x_q;
			REG_ORIGIN_Y: prdata = origin_y_q;
			REG_LINE_TAB: prdata = PDATA_W'(line_tab_q);
			default:      prdata = '0;
		endcase
	end

	srtd_front u_front (
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.is_edge       (is_edge),
		.is_straight   (is_straight),
		.general_line  (general_line),
		.vertical_line (vertical_line),
		.delta_x       (delta_x),
		.delta_y       (delta_y),
		.control_dx    (control_dx),
		.control_dy    (control_dy),
		.change_flags  (change_flags),
		.new_fill0     (new_fill0),
		.new_fill1     (new_fill1),
		.new_line      (new_line),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_op          (q_op)
	);

	srtd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_op   (q_op),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head_op   (q_head)
	);

	srtd_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr          (cfg_wr),
		.q_not_empty     (q_not_empty),
		.q_head          (q_head),
		.q_pop           (q_pop),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.start_x         (start_x),
		.start_y         (start_y),
		.ctrl_x          (ctrl_x),
		.ctrl_y          (ctrl_y),
		.end_x           (end_x),
		.end_y           (end_y),
		.is_curve        (is_curve),
		.fill0_style     (fill0_style),
		.fill1_style     (fill1_style),
		.line_style_out  (line_style_out),
		.fill_table_bank (fill_table_bank),
		.line_table_bank (line_table_bank)
	);

endmodule

// File: rtl/core/srtd_checker.sv
// port-level checks for the shape record to edge decoder, bound to the top level
`timescale 1ns / 1ps
module srtd_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic [srtd_pkg::PADDR_W-1:0]        paddr,
	input  logic [srtd_pkg::PDATA_W-1:0]        prdata,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic signed [srtd_pkg::WORD_W-1:0]  start_x,
	input  logic signed [srtd_pkg::WORD_W-1:0]  end_x,
	input  logic signed [srtd_pkg::WORD_W-1:0]  ctrl_x,
	input  logic signed [srtd_pkg::WORD_W-1:0]  ctrl_y,
	input  logic                                is_curve
);

	// no item shown in the cycle after reset is seen
	a_no_out_in_reset: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("item shown during reset");

	// straight edges carry a zero control point
	a_straight_ctrl: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !is_curve) |-> (ctrl_x == '0 && ctrl_y == '0))
		else $error("straight edge with non-zero control point");

	// line table flag reads back as one bit
	a_line_tab_read: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && paddr[3:2] == srtd_pkg::REG_LINE_TAB) |-> (prdata[31:1] == '0))
		else $error("line table register reads wider than one bit");

	// a stalled item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(start_x) && $stable(end_x)))
		else $error("stalled item changed");

endmodule

bind shape_record_to_edge_decoder_top srtd_checker u_srtd_checker (.*);
